// ===== hdl/mer_pkg.sv =====
package mer_pkg;

  localparam int AXIS_BITS_DEF  = 9;
  localparam int COORD_BITS_DEF = 10;

  // beat field widths and positions
  localparam int AXIS_FW  = 9;
  localparam int COORD_FW = 10;
  localparam int CX_LSB   = 0;
  localparam int CY_LSB   = CX_LSB + COORD_FW;
  localparam int A_LSB    = CY_LSB + COORD_FW;
  localparam int B_LSB    = A_LSB + AXIS_FW;
  localparam int IN_DW    = 40;
  localparam int PT_W     = 12;
  localparam int OUT_DW   = 8 * PT_W;
  localparam int OUT_UW   = 2;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_R1,
    PH_R2,
    PH_FIN
  } phase_e;

  typedef enum logic [2:0] {
    MX_A,
    MX_B,
    MX_A2,
    MX_B2,
    MX_X,
    MX_P
  } mx_e;

  typedef enum logic [3:0] {
    MY_A,
    MY_B,
    MY_A2,
    MY_S,
    MY_X,
    MY_1M2A,
    MY_1M2B,
    MY_2XP3,
    MY_2YP3,
    MY_1MX,
    MY_1MY
  } my_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_A2,
    WR_B2,
    WR_A4S
  } wr_e;

  typedef enum logic [2:0] {
    DEC_NONE,
    DEC_LD_A2,
    DEC_LD_B2,
    DEC_ADD2,
    DEC_ADD4C
  } dec_e;

  typedef enum logic [2:0] {
    OFF_NONE,
    OFF_START,
    OFF_R2,
    OFF_STEP1,
    OFF_STEP2
  } off_e;

  typedef enum logic [1:0] {
    J_NEXT,
    J_ALWAYS,
    J_R1_FAIL,
    J_R2_FAIL
  } jmp_e;

  localparam int UPC_W = 5;
  typedef logic [UPC_W-1:0] upc_t;

  // microprogram entry points and steps
  localparam upc_t UPC_ST0   = 5'd0;
  localparam upc_t UPC_ST1   = 5'd1;
  localparam upc_t UPC_ST2   = 5'd2;
  localparam upc_t UPC_ST3   = 5'd3;
  localparam upc_t UPC_ST4   = 5'd4;
  localparam upc_t UPC_EMIT  = 5'd5;
  localparam upc_t UPC_R1_0  = 5'd6;
  localparam upc_t UPC_R1_1  = 5'd7;
  localparam upc_t UPC_R1_2  = 5'd8;
  localparam upc_t UPC_R1_3  = 5'd9;
  localparam upc_t UPC_R1_4  = 5'd10;
  localparam upc_t UPC_EN2_0 = 5'd11;
  localparam upc_t UPC_EN2_1 = 5'd12;
  localparam upc_t UPC_R2_0  = 5'd13;
  localparam upc_t UPC_R2_1  = 5'd14;
  localparam upc_t UPC_R2_2  = 5'd15;
  localparam upc_t UPC_R2_3  = 5'd16;
  localparam upc_t UPC_R2_4  = 5'd17;
  localparam upc_t UPC_FIN   = 5'd18;

  typedef struct packed {
    mx_e    mx;
    my_e    my;
    wr_e    wr;
    dec_e   dec;
    off_e   off;
    logic   ph_wr;
    phase_e ph;
    jmp_e   jmp;
    upc_t   target;
    logic   emit;
    logic   emit_valid;
  } ctrl_t;

  typedef struct packed {
    phase_e phase;
    logic   r1_ok;
    logic   r2_ok;
  } stat_t;

  typedef struct packed {
    logic signed [PT_W-1:0] p3_y;
    logic signed [PT_W-1:0] p3_x;
    logic signed [PT_W-1:0] p2_y;
    logic signed [PT_W-1:0] p2_x;
    logic signed [PT_W-1:0] p1_y;
    logic signed [PT_W-1:0] p1_x;
    logic signed [PT_W-1:0] p0_y;
    logic signed [PT_W-1:0] p0_x;
    logic                   done_res;
    logic                   points_valid;
  } res_t;

  function automatic ctrl_t rom_word(input upc_t a);
    ctrl_t w;
    w = '0;
    case (a)
      UPC_ST0: begin
        w.off = OFF_START; w.ph_wr = 1'b1; w.ph = PH_R1;
        w.mx = MX_A; w.my = MY_A;
      end
      UPC_ST1: begin
        w.wr = WR_A2; w.mx = MX_B; w.my = MY_B;
      end
      UPC_ST2: begin
        w.wr = WR_B2; w.mx = MX_A2; w.my = MY_A2;
      end
      UPC_ST3: begin
        w.wr = WR_A4S; w.mx = MX_A2; w.my = MY_1M2B;
      end
      UPC_ST4: begin
        w.dec = DEC_LD_B2;
      end
      UPC_EMIT: begin
        w.emit = 1'b1; w.emit_valid = 1'b1;
      end
      UPC_R1_0: begin
        w.mx = MX_X; w.my = MY_X;
      end
      UPC_R1_1: begin
        w.mx = MX_P; w.my = MY_S;
      end
      UPC_R1_2: begin
        w.jmp = J_R1_FAIL; w.target = UPC_EN2_0;
        w.mx = MX_B2; w.my = MY_2XP3;
      end
      UPC_R1_3: begin
        w.dec = DEC_ADD2; w.mx = MX_A2; w.my = MY_1MY;
      end
      UPC_R1_4: begin
        w.dec = DEC_ADD4C; w.off = OFF_STEP1;
        w.jmp = J_ALWAYS; w.target = UPC_EMIT;
      end
      UPC_EN2_0: begin
        w.off = OFF_R2; w.ph_wr = 1'b1; w.ph = PH_R2;
        w.mx = MX_B2; w.my = MY_1M2A;
      end
      UPC_EN2_1: begin
        w.dec = DEC_LD_A2; w.jmp = J_ALWAYS; w.target = UPC_EMIT;
      end
      UPC_R2_0: begin
        w.mx = MX_X; w.my = MY_X;
      end
      UPC_R2_1: begin
        w.mx = MX_P; w.my = MY_S;
      end
      UPC_R2_2: begin
        w.jmp = J_R2_FAIL; w.target = UPC_FIN;
        w.mx = MX_A2; w.my = MY_2YP3;
      end
      UPC_R2_3: begin
        w.dec = DEC_ADD2; w.mx = MX_B2; w.my = MY_1MX;
      end
      UPC_R2_4: begin
        w.dec = DEC_ADD4C; w.off = OFF_STEP2;
        w.jmp = J_ALWAYS; w.target = UPC_EMIT;
      end
      UPC_FIN: begin
        w.ph_wr = 1'b1; w.ph = PH_FIN; w.emit = 1'b1;
      end
      default: begin
        w.emit = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/mer_seq.sv =====
module mer_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_valid_i,
  input  logic            op_i,
  output logic            s_ready_o,
  input  mer_pkg::stat_t  stat_i,
  input  logic            obuf_rdy_i,
  output mer_pkg::ctrl_t  ctrl_o,
  output logic            step_en_o,
  output logic            ld_o,
  output logic            emit_ld_o
);

  logic          busy_q, busy_d;
  mer_pkg::upc_t upc_q, upc_d;
  logic          accept;
  logic          taken;
  mer_pkg::upc_t entry;

  always_comb begin
    ctrl_o    = mer_pkg::rom_word(upc_q);
    s_ready_o = !busy_q;
    accept    = s_valid_i && !busy_q;
    ld_o      = accept && (op_i == mer_pkg::OP_START);
    step_en_o = busy_q && (!ctrl_o.emit || obuf_rdy_i);
    emit_ld_o = step_en_o && ctrl_o.emit;

    case (ctrl_o.jmp)
      mer_pkg::J_NEXT:    taken = 1'b0;
      mer_pkg::J_ALWAYS:  taken = 1'b1;
      mer_pkg::J_R1_FAIL: taken = !stat_i.r1_ok;
      mer_pkg::J_R2_FAIL: taken = !stat_i.r2_ok;
      default:            taken = 1'b0;
    endcase

    if (op_i == mer_pkg::OP_START) begin
      entry = mer_pkg::UPC_ST0;
    end else begin
      case (stat_i.phase)
        mer_pkg::PH_R1: entry = mer_pkg::UPC_R1_0;
        mer_pkg::PH_R2: entry = mer_pkg::UPC_R2_0;
        default:        entry = mer_pkg::UPC_FIN;
      endcase
    end

    busy_d = busy_q;
    upc_d  = upc_q;
    if (accept) begin
      busy_d = 1'b1;
      upc_d  = entry;
    end else if (step_en_o) begin
      if (ctrl_o.emit) begin
        busy_d = 1'b0;
      end else if (taken) begin
        upc_d = ctrl_o.target;
      end else begin
        upc_d = upc_q + mer_pkg::upc_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      upc_q  <= mer_pkg::UPC_FIN;
    end else begin
      busy_q <= busy_d;
      upc_q  <= upc_d;
    end
  end

endmodule

// ===== hdl/mer_dp.sv =====
module mer_dp #(
  parameter int AXIS_BITS  = mer_pkg::AXIS_BITS_DEF,
  parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_en_i,
  input  mer_pkg::ctrl_t        ctrl_i,
  input  logic                  ld_i,
  input  logic [AXIS_BITS-1:0]  a_i,
  input  logic [AXIS_BITS-1:0]  b_i,
  input  logic [COORD_BITS-1:0] cx_i,
  input  logic [COORD_BITS-1:0] cy_i,
  output mer_pkg::stat_t        stat_o,
  output mer_pkg::res_t         res_o
);

  localparam int OW  = AXIS_BITS + 2;
  localparam int XW  = 2 * AXIS_BITS + 3;
  localparam int YW  = 2 * AXIS_BITS + 2;
  localparam int PW  = XW + YW;
  localparam int DW  = 4 * AXIS_BITS + 6;
  localparam int SW  = 2 * AXIS_BITS + 1;
  localparam int EW0 = (COORD_BITS > OW) ? COORD_BITS : OW;
  localparam int EW  = (EW0 > mer_pkg::PT_W) ? EW0 : mer_pkg::PT_W;
  localparam logic signed [YW-1:0] ONE_Y   = YW'(1);
  localparam logic signed [YW-1:0] THREE_Y = YW'(3);
  localparam logic signed [OW-1:0] ONE_O   = OW'(1);

  logic [AXIS_BITS-1:0]     a_q, a_d, b_q, b_d;
  logic [COORD_BITS-1:0]    cx_q, cx_d, cy_q, cy_d;
  logic signed [OW-1:0]     ox_q, ox_d, oy_q, oy_d;
  logic [2*AXIS_BITS-1:0]   a2_q, a2_d, b2_q, b2_d;
  logic [SW-1:0]            s_q, s_d;
  logic [4*AXIS_BITS-1:0]   a4_q, a4_d;
  logic signed [PW-1:0]     p_q, p_d, prod;
  logic [DW-1:0]            dec_q, dec_d;
  logic                     neg_q, neg_d;
  mer_pkg::phase_e          phase_q, phase_d;

  logic signed [XW-1:0]     mx_v;
  logic signed [YW-1:0]     my_v, a_y, b_y, x_y, y_y;
  logic [PW-1:0]            p_u;
  logic [EW-1:0]            cx_e, cy_e, ox_e, oy_e, xp, xm, yp, ym;

  assign a_y = YW'(a_q);
  assign b_y = YW'(b_q);
  assign x_y = YW'(ox_q);
  assign y_y = YW'(oy_q);

  always_comb begin
    case (ctrl_i.mx)
      mer_pkg::MX_A:  mx_v = XW'(a_q);
      mer_pkg::MX_B:  mx_v = XW'(b_q);
      mer_pkg::MX_A2: mx_v = XW'(a2_q);
      mer_pkg::MX_B2: mx_v = XW'(b2_q);
      mer_pkg::MX_X:  mx_v = XW'(ox_q);
      mer_pkg::MX_P:  mx_v = p_q[XW-1:0];
      default:        mx_v = '0;
    endcase
    case (ctrl_i.my)
      mer_pkg::MY_A:    my_v = a_y;
      mer_pkg::MY_B:    my_v = b_y;
      mer_pkg::MY_A2:   my_v = YW'(a2_q);
      mer_pkg::MY_S:    my_v = YW'(s_q);
      mer_pkg::MY_X:    my_v = x_y;
      mer_pkg::MY_1M2A: my_v = ONE_Y - (a_y <<< 1);
      mer_pkg::MY_1M2B: my_v = ONE_Y - (b_y <<< 1);
      mer_pkg::MY_2XP3: my_v = (x_y <<< 1) + THREE_Y;
      mer_pkg::MY_2YP3: my_v = (y_y <<< 1) + THREE_Y;
      mer_pkg::MY_1MX:  my_v = ONE_Y - x_y;
      mer_pkg::MY_1MY:  my_v = ONE_Y - y_y;
      default:          my_v = '0;
    endcase
  end

  assign prod = mx_v * my_v;

  // region tests against the product held from the previous step
  assign p_u          = p_q;
  assign stat_o.phase = phase_q;
  assign stat_o.r1_ok = (s_q != '0) && (p_u <= PW'(a4_q));
  assign stat_o.r2_ok = (s_q != '0) && (p_u > PW'(a4_q));

  always_comb begin
    a_d     = ld_i ? a_i  : a_q;
    b_d     = ld_i ? b_i  : b_q;
    cx_d    = ld_i ? cx_i : cx_q;
    cy_d    = ld_i ? cy_i : cy_q;
    ox_d    = ox_q;
    oy_d    = oy_q;
    a2_d    = a2_q;
    b2_d    = b2_q;
    s_d     = s_q;
    a4_d    = a4_q;
    p_d     = p_q;
    dec_d   = dec_q;
    neg_d   = neg_q;
    phase_d = phase_q;
    if (step_en_i) begin
      p_d = prod;
      case (ctrl_i.wr)
        mer_pkg::WR_A2:  a2_d = p_q[2*AXIS_BITS-1:0];
        mer_pkg::WR_B2:  b2_d = p_q[2*AXIS_BITS-1:0];
        mer_pkg::WR_A4S: begin
          a4_d = p_q[4*AXIS_BITS-1:0];
          s_d  = SW'(a2_q) + SW'(b2_q);
        end
        default: ;
      endcase
      case (ctrl_i.dec)
        mer_pkg::DEC_LD_A2: dec_d = DW'(p_q) + DW'(a2_q);
        mer_pkg::DEC_LD_B2: dec_d = DW'(p_q) + DW'(b2_q);
        mer_pkg::DEC_ADD2: begin
          neg_d = dec_q[DW-1];
          dec_d = dec_q + (DW'(p_q) << 1);
        end
        mer_pkg::DEC_ADD4C: begin
          if (!neg_q) begin
            dec_d = dec_q + (DW'(p_q) << 2);
          end
        end
        default: ;
      endcase
      case (ctrl_i.off)
        mer_pkg::OFF_START: begin
          ox_d = '0;
          oy_d = OW'(b_q);
        end
        mer_pkg::OFF_R2: begin
          ox_d = OW'(a_q);
          oy_d = '0;
        end
        mer_pkg::OFF_STEP1: begin
          ox_d = ox_q + ONE_O;
          if (!neg_q) begin
            oy_d = oy_q - ONE_O;
          end
        end
        mer_pkg::OFF_STEP2: begin
          oy_d = oy_q + ONE_O;
          if (!neg_q) begin
            ox_d = ox_q - ONE_O;
          end
        end
        default: ;
      endcase
      if (ctrl_i.ph_wr) begin
        phase_d = ctrl_i.ph;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= mer_pkg::PH_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    cx_q  <= cx_d;
    cy_q  <= cy_d;
    ox_q  <= ox_d;
    oy_q  <= oy_d;
    a2_q  <= a2_d;
    b2_q  <= b2_d;
    s_q   <= s_d;
    a4_q  <= a4_d;
    p_q   <= p_d;
    dec_q <= dec_d;
    neg_q <= neg_d;
  end

  // four mirrored points, wrapped to the point width
  assign cx_e = EW'(cx_q);
  assign cy_e = EW'(cy_q);
  assign ox_e = EW'(ox_q);
  assign oy_e = EW'(oy_q);
  assign xp   = cx_e + ox_e;
  assign xm   = cx_e - ox_e;
  assign yp   = cy_e + oy_e;
  assign ym   = cy_e - oy_e;

  always_comb begin
    res_o              = '0;
    res_o.done_res     = !ctrl_i.emit_valid;
    if (ctrl_i.emit_valid) begin
      res_o.points_valid = 1'b1;
      res_o.p0_x         = xp[mer_pkg::PT_W-1:0];
      res_o.p0_y         = yp[mer_pkg::PT_W-1:0];
      res_o.p1_x         = xp[mer_pkg::PT_W-1:0];
      res_o.p1_y         = ym[mer_pkg::PT_W-1:0];
      res_o.p2_x         = xm[mer_pkg::PT_W-1:0];
      res_o.p2_y         = ym[mer_pkg::PT_W-1:0];
      res_o.p3_x         = xm[mer_pkg::PT_W-1:0];
      res_o.p3_y         = yp[mer_pkg::PT_W-1:0];
    end
  end

endmodule

// ===== hdl/mer_obuf.sv =====
module mer_obuf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          ld_i,
  input  mer_pkg::res_t res_i,
  output logic          rdy_o,
  output logic          m_valid_o,
  input  logic          m_ready_i,
  output mer_pkg::res_t res_o
);

  logic          full_q, full_d;
  mer_pkg::res_t res_q;

  assign rdy_o     = !full_q || m_ready_i;
  assign m_valid_o = full_q;
  assign res_o     = res_q;

  always_comb begin
    full_d = full_q;
    if (ld_i) begin
      full_d = 1'b1;
    end else if (m_ready_i) begin
      full_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      res_q <= res_i;
    end
  end

endmodule

// ===== hdl/midpoint_ellipse_rasterizer_unit.sv =====
// channel   dir  tdata fields, low bit first                 tuser
// s_axis    in   center_x, center_y, axis_a, axis_b, pad     op
// m_axis    out  p0_x p0_y p1_x p1_y p2_x p2_y p3_x p3_y     points_valid, done_res
//
// a beat is taken only while the sequencer is idle; one multiplier, whose
// product is registered before use, sets the step count
// the output register holds a finished beat while the next one is taken
// asynchronous active-low reset returns the block to idle
module midpoint_ellipse_rasterizer_unit #(
  parameter int AXIS_BITS  = mer_pkg::AXIS_BITS_DEF,
  parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // center_x, center_y, axis_a, axis_b
  input  logic [mer_pkg::IN_DW-1:0]  s_axis_tdata,
  // op
  input  logic [0:0]                 s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y
  output logic [mer_pkg::OUT_DW-1:0] m_axis_tdata,
  // points_valid, done_res
  output logic [mer_pkg::OUT_UW-1:0] m_axis_tuser
);

  mer_pkg::ctrl_t        ctrl;
  mer_pkg::stat_t        stat;
  mer_pkg::res_t         res_d;
  mer_pkg::res_t         res_q;
  logic                  step_en;
  logic                  ld;
  logic                  emit_ld;
  logic                  obuf_rdy;
  logic [AXIS_BITS-1:0]  a_in, b_in;
  logic [COORD_BITS-1:0] cx_in, cy_in;

  assign cx_in = COORD_BITS'(s_axis_tdata[mer_pkg::CX_LSB +: mer_pkg::COORD_FW]);
  assign cy_in = COORD_BITS'(s_axis_tdata[mer_pkg::CY_LSB +: mer_pkg::COORD_FW]);
  assign a_in  = AXIS_BITS'(s_axis_tdata[mer_pkg::A_LSB +: mer_pkg::AXIS_FW]);
  assign b_in  = AXIS_BITS'(s_axis_tdata[mer_pkg::B_LSB +: mer_pkg::AXIS_FW]);

  mer_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .op_i       (s_axis_tuser[0]),
    .s_ready_o  (s_axis_tready),
    .stat_i     (stat),
    .obuf_rdy_i (obuf_rdy),
    .ctrl_o     (ctrl),
    .step_en_o  (step_en),
    .ld_o       (ld),
    .emit_ld_o  (emit_ld)
  );

  mer_dp #(
    .AXIS_BITS  (AXIS_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (step_en),
    .ctrl_i    (ctrl),
    .ld_i      (ld),
    .a_i       (a_in),
    .b_i       (b_in),
    .cx_i      (cx_in),
    .cy_i      (cy_in),
    .stat_o    (stat),
    .res_o     (res_d)
  );

  mer_obuf u_obuf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ld_i      (emit_ld),
    .res_i     (res_d),
    .rdy_o     (obuf_rdy),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .res_o     (res_q)
  );

  assign m_axis_tdata = {res_q.p3_y, res_q.p3_x, res_q.p2_y, res_q.p2_x,
                         res_q.p1_y, res_q.p1_x, res_q.p0_y, res_q.p0_x};
  assign m_axis_tuser = {res_q.done_res, res_q.points_valid};

endmodule

// ===== hdl/mer_chk.sv =====
module mer_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic [mer_pkg::IN_DW-1:0]  s_axis_tdata,
  input logic [0:0]                 s_axis_tuser,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [mer_pkg::OUT_DW-1:0] m_axis_tdata,
  input logic [mer_pkg::OUT_UW-1:0] m_axis_tuser
);

  localparam int W = mer_pkg::PT_W;

  // held beat stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output beat changed while stalled");

  // a beat is either a point group or the done marker
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser[0] ^ m_axis_tuser[1]))
    else $error("points_valid and done_res not exclusive");

  a_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> (m_axis_tdata == '0))
    else $error("done beat carries point data");

  // mirrored points share coordinates
  a_sym: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |->
      (m_axis_tdata[0 +: W] == m_axis_tdata[2*W +: W]) &&
      (m_axis_tdata[4*W +: W] == m_axis_tdata[6*W +: W]) &&
      (m_axis_tdata[W +: W] == m_axis_tdata[7*W +: W]) &&
      (m_axis_tdata[3*W +: W] == m_axis_tdata[5*W +: W]))
    else $error("point group not symmetric");

  // no input beat is taken while a step is in flight
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second beat taken before first finished");

endmodule

bind midpoint_ellipse_rasterizer_unit mer_chk u_mer_chk (.*);
